// File: hw/rtl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared widths, constants and types of the PI duty controller with capture.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int GAIN_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int ERR_W      = 11;
  localparam int INTEG_W    = 11;
  localparam int POS_W      = 8;
  localparam int DEC_W      = 4;
  localparam int CMP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // shared multiplier: signed 25 x 25
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // effort accumulator and clamped percent (8 fractional bits)
  localparam int ACC_W = 28;
  localparam int U_W   = 15;
  localparam logic signed [ACC_W-1:0] PCT_HALF = ACC_W'(12800);
  localparam logic signed [ACC_W-1:0] PCT_FULL = ACC_W'(25600);

  // u*period < 2^31; x = (u*period) >> 8 < 2^23
  // floor(x / 100) = (x * RECIP_M) >> RECIP_SHIFT, exact for x < 2^23
  localparam int SCALE_LSB   = 8;
  localparam int X_W         = 23;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_M = 24'd10737419;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW    = 3'd4;

  localparam logic [GAIN_W-1:0]   KP_RST     = 16'd0;
  localparam logic [GAIN_W-1:0]   KI_RST     = 16'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd2400;
  localparam logic [SAMPLE_W-1:0] HIGH_RST   = 10'd800;
  localparam logic [SAMPLE_W-1:0] LOW_RST    = 10'd200;

  typedef struct packed {
    logic                valid;
    logic [POS_W-1:0]    index;
    logic [SAMPLE_W-1:0] measured;
    logic [SAMPLE_W-1:0] reference;
    logic                done;
  } cap_t;

endpackage

// File: hw/rtl/pwc_if.sv
// ----------------------------------------------------------------------------
// pwc interfaces
// Valid/ready channels: sample input, result output, configuration write.
// ----------------------------------------------------------------------------
interface pwc_in_if
  import pwc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;
  logic                start_capture;

  modport source(output valid, adc_sample, start_capture, input ready);
  modport sink(input valid, adc_sample, start_capture, output ready);
endinterface

interface pwc_out_if
  import pwc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CMP_W-1:0]    duty_compare;
  logic                capture_valid;
  logic [POS_W-1:0]    capture_index;
  logic [SAMPLE_W-1:0] capture_measured;
  logic [SAMPLE_W-1:0] capture_reference;
  logic                capture_done;

  modport source(output valid, duty_compare, capture_valid, capture_index,
                 capture_measured, capture_reference, capture_done, input ready);
  modport sink(input valid, duty_compare, capture_valid, capture_index,
               capture_measured, capture_reference, capture_done, output ready);
endinterface

interface pwc_cfg_if
  import pwc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/pwc_mul.sv
// ----------------------------------------------------------------------------
// pwc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pwc_mul
  import pwc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: hw/rtl/pwc_track.sv
// ----------------------------------------------------------------------------
// pwc_track
// Reference wave, error, clamped integrator and decimated capture state.
// ----------------------------------------------------------------------------
module pwc_track
  import pwc_pkg::*;
#(
  parameter int WAVE_LEN    = 1000,
  parameter int PLOT_POINTS = 200,
  parameter int DECIMATION  = 10,
  parameter int INT_LIMIT   = 1000
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      clr_i,
  input  logic [SAMPLE_W-1:0]       sample_i,
  input  logic                      start_i,
  input  logic [SAMPLE_W-1:0]       wave_high_i,
  input  logic [SAMPLE_W-1:0]       wave_low_i,
  output logic signed [ERR_W-1:0]   err_o,
  output logic signed [INTEG_W-1:0] integ_o,
  output cap_t                      cap_o
);

  localparam int PHASE_W = $clog2(WAVE_LEN);
  localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(WAVE_LEN / 2);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(WAVE_LEN - 1);
  localparam logic signed [INTEG_W:0] LIM_P = (INTEG_W + 1)'(INT_LIMIT);
  localparam logic signed [INTEG_W:0] LIM_N = -LIM_P;

  logic [PHASE_W-1:0]       phase_q, phase_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic [DEC_W-1:0]         dec_q, dec_d, dec_inc;
  logic [POS_W-1:0]         pos_q, pos_d, pos_inc, pos_n;
  logic                     capt_q, capt_d;
  logic [SAMPLE_W-1:0]      ref_lvl;
  logic signed [INTEG_W:0]  acc;
  logic                     cap_on, hit, run_end;

  assign ref_lvl = (phase_q < PHASE_HALF) ? wave_high_i : wave_low_i;
  assign err_o   = $signed({1'b0, ref_lvl}) - $signed({1'b0, sample_i});
  assign acc     = {integ_q[INTEG_W-1], integ_q} + {err_o[ERR_W-1], err_o};

  assign cap_on  = capt_q | start_i;
  assign dec_inc = dec_q + 1'b1;
  assign hit     = cap_on && (dec_inc == DEC_W'(DECIMATION));
  assign pos_inc = pos_q + 1'b1;
  assign pos_n   = hit ? pos_inc : pos_q;
  assign run_end = cap_on && (pos_n == POS_W'(PLOT_POINTS));

  always_comb begin
    phase_d = (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
    priority if (acc > LIM_P) begin
      integ_d = LIM_P[INTEG_W-1:0];
    end else if (acc < LIM_N) begin
      integ_d = LIM_N[INTEG_W-1:0];
    end else begin
      integ_d = acc[INTEG_W-1:0];
    end
    capt_d = cap_on && !run_end;
    dec_d  = cap_on ? (hit ? '0 : dec_inc) : dec_q;
    pos_d  = run_end ? '0 : pos_n;
  end

  always_comb begin
    cap_o.valid     = hit;
    cap_o.index     = hit ? pos_q : '0;
    cap_o.measured  = hit ? sample_i : '0;
    cap_o.reference = hit ? ref_lvl : '0;
    cap_o.done      = hit && run_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      integ_q <= '0;
      dec_q   <= '0;
      pos_q   <= '0;
      capt_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      integ_q <= integ_d;
      dec_q   <= dec_d;
      pos_q   <= pos_d;
      capt_q  <= capt_d;
    end else if (clr_i) begin
      integ_q <= '0;
    end
  end

  assign integ_o = integ_q;

endmodule

// File: hw/rtl/pi_pwm_controller_with_capture_top.sv
// ----------------------------------------------------------------------------
// pi_pwm_controller_with_capture_top
// PI duty controller with clamped integrator and decimated capture stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one beat per control tick (adc_sample, start_capture).
//   out_o : one beat per input beat: duty compare value plus capture fields;
//           capture fields read zero on ticks without a capture.
//   cfg_i : register writes (0 kp, 1 ki, 2 period, 3 wave high, 4 wave low),
//           always ready; writing kp or ki clears the integrator. Other
//           indexes are dropped. Write only while no tick is in flight.
// Sequencing: a tick steps through KP, KI, SUM, PER, RECIP and OUT, and the
//   result is then held in the output register. A tick uses the one shared
//   multiplier four times (kp*e, ki*i, u*period, scale by 1/100), so a new
//   input beat is taken only once the previous tick has left the sequencer.
// in_i.ready is high only while the sequencer is idle. A finished result
//   waits in the output register; if the receiver stalls, the next tick is
//   still taken and held in its last step until that register frees up.
// Reset clears wave phase, integrator, capture state and restores the
//   register defaults (period 2400, high 800, low 200, gains 0).
// ----------------------------------------------------------------------------
module pi_pwm_controller_with_capture_top
  import pwc_pkg::*;
#(
  parameter int WAVE_LEN    = 1000,
  parameter int PLOT_POINTS = 200,
  parameter int DECIMATION  = 10,
  parameter int INT_LIMIT   = 1000
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pwc_in_if.sink     in_i,
  pwc_out_if.source  out_o,
  pwc_cfg_if.sink    cfg_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KP    = 3'd1;
  localparam logic [2:0] ST_KI    = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_PER   = 3'd4;
  localparam logic [2:0] ST_RECIP = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [GAIN_W-1:0]         kp_q, ki_q;
  logic [PERIOD_W-1:0]       period_q;
  logic [SAMPLE_W-1:0]       high_q, low_q;
  logic signed [ERR_W-1:0]   err, err_q;
  logic signed [INTEG_W-1:0] integ;
  cap_t                      cap, cap_q;
  logic signed [ACC_W-1:0]   acc_q, sum;
  logic [U_W-1:0]            u_q, u_d;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      in_beat, cfg_beat, gain_clr, load_out;
  logic                      out_valid_q;
  logic [CMP_W-1:0]          duty_q;
  cap_t                      out_cap_q;

  assign in_beat  = in_i.valid && in_i.ready;
  assign cfg_beat = cfg_i.valid && cfg_i.ready;
  assign gain_clr = cfg_beat && ((cfg_i.index == REG_KP) || (cfg_i.index == REG_KI));
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign load_out    = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= KP_RST;
      ki_q     <= KI_RST;
      period_q <= PERIOD_RST;
      high_q   <= HIGH_RST;
      low_q    <= LOW_RST;
    end else if (cfg_beat) begin
      unique case (cfg_i.index)
        REG_KP:     kp_q     <= cfg_i.data;
        REG_KI:     ki_q     <= cfg_i.data;
        REG_PERIOD: period_q <= cfg_i.data;
        REG_HIGH:   high_q   <= cfg_i.data[SAMPLE_W-1:0];
        REG_LOW:    low_q    <= cfg_i.data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  pwc_track #(
    .WAVE_LEN    (WAVE_LEN),
    .PLOT_POINTS (PLOT_POINTS),
    .DECIMATION  (DECIMATION),
    .INT_LIMIT   (INT_LIMIT)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_beat),
    .clr_i       (gain_clr),
    .sample_i    (in_i.adc_sample),
    .start_i     (in_i.start_capture),
    .wave_high_i (high_q),
    .wave_low_i  (low_q),
    .err_o       (err),
    .integ_o     (integ),
    .cap_o       (cap)
  );

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      err_q <= err;
      cap_q <= cap;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_KP: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mul_b  = {{(MUL_W-GAIN_W){1'b0}}, kp_q};
      end
      ST_KI: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-INTEG_W){integ[INTEG_W-1]}}, integ};
        mul_b  = {{(MUL_W-GAIN_W){1'b0}}, ki_q};
      end
      ST_PER: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-U_W){1'b0}}, u_q};
        mul_b  = {{(MUL_W-PERIOD_W){1'b0}}, period_q};
      end
      ST_RECIP: begin
        mul_en = 1'b1;
        mul_a  = {{(MUL_W-X_W){1'b0}}, prod[SCALE_LSB+X_W-1:SCALE_LSB]};
        mul_b  = {{(MUL_W-RECIP_W){1'b0}}, RECIP_M};
      end
      default: ;
    endcase
  end

  pwc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign sum = acc_q + prod[ACC_W-1:0] + PCT_HALF;

  always_comb begin
    priority if (sum < 0) begin
      u_d = '0;
    end else if (sum > PCT_FULL) begin
      u_d = PCT_FULL[U_W-1:0];
    end else begin
      u_d = sum[U_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_KI) begin
      acc_q <= prod[ACC_W-1:0];
    end
    if (state_q == ST_SUM) begin
      u_q <= u_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_beat) state_d = ST_KP;
      ST_KP:    state_d = ST_KI;
      ST_KI:    state_d = ST_SUM;
      ST_SUM:   state_d = ST_PER;
      ST_PER:   state_d = ST_RECIP;
      ST_RECIP: state_d = ST_OUT;
      ST_OUT:   if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      duty_q    <= prod[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
      out_cap_q <= cap_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.duty_compare      = duty_q;
  assign out_o.capture_valid     = out_cap_q.valid;
  assign out_o.capture_index     = out_cap_q.index;
  assign out_o.capture_measured  = out_cap_q.measured;
  assign out_o.capture_reference = out_cap_q.reference;
  assign out_o.capture_done      = out_cap_q.done;

endmodule

// File: hw/rtl/pwc_assert.sv
// ----------------------------------------------------------------------------
// pwc_assert
// Port-level checks of the PI duty controller, bound to the top level.
// ----------------------------------------------------------------------------
module pwc_assert
  import pwc_pkg::*;
#(
  parameter int PLOT_POINTS = 200
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [CMP_W-1:0]    duty_i,
  input logic                cap_valid_i,
  input logic [POS_W-1:0]    cap_index_i,
  input logic [SAMPLE_W-1:0] cap_measured_i,
  input logic [SAMPLE_W-1:0] cap_reference_i,
  input logic                cap_done_i
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PLOT_POINTS - 1);

  // one tick in flight at a time
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a tick is in flight");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && cap_done_i |-> cap_valid_i && (cap_index_i == LAST_POS))
    else $error("done flagged off the last capture");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !cap_valid_i |->
      (cap_index_i == '0) && (cap_measured_i == '0) &&
      (cap_reference_i == '0) && !cap_done_i)
    else $error("capture fields nonzero without capture");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && cap_valid_i |-> (cap_index_i <= LAST_POS))
    else $error("capture index out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(duty_i))
    else $error("stalled output beat changed");

endmodule

bind pi_pwm_controller_with_capture_top pwc_assert #(
  .PLOT_POINTS (PLOT_POINTS)
) u_pwc_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .duty_i          (out_o.duty_compare),
  .cap_valid_i     (out_o.capture_valid),
  .cap_index_i     (out_o.capture_index),
  .cap_measured_i  (out_o.capture_measured),
  .cap_reference_i (out_o.capture_reference),
  .cap_done_i      (out_o.capture_done)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PI duty controller with decimated capture.
// Drives register writes, and control ticks with random gaps; predicts duty
// compare and capture fields per tick, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb
  import pwc_pkg::*;
();

  localparam int WAVE_LEN     = 1000;
  localparam int PLOT_POINTS  = 200;
  localparam int DECIMATION   = 10;
  localparam int INT_LIMIT    = 1000;
  localparam int LATENCY      = 6;
  localparam int PHASE_TICKS  = 300;
  localparam int RAND_TICKS   = 1200;
  localparam int MAX_PHASES   = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct packed {
    logic [CMP_W-1:0] duty;
    cap_t             cap;
  } tick_res_t;

  class pi_duty_sb;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [PERIOD_W-1:0]       period;
    logic [SAMPLE_W-1:0]       level_hi;
    logic [SAMPLE_W-1:0]       level_lo;
    logic [9:0]                wave_phase;
    logic signed [INTEG_W-1:0] integ;
    logic [DEC_W-1:0]          dec_cnt;
    logic [POS_W-1:0]          cap_pos;
    bit                        capturing;
    tick_res_t                 due[$];
    int                        errors;

    function new();
      kp         = KP_RST;
      ki         = KI_RST;
      period     = PERIOD_RST;
      level_hi   = HIGH_RST;
      level_lo   = LOW_RST;
      wave_phase = '0;
      integ      = '0;
      dec_cnt    = '0;
      cap_pos    = '0;
      capturing  = 1'b0;
      errors     = 0;
    endfunction

    function logic [SAMPLE_W-1:0] cur_level();
      return (wave_phase < WAVE_LEN / 2) ? level_hi : level_lo;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_KP: begin
          kp    = data[GAIN_W-1:0];
          integ = '0;
        end
        REG_KI: begin
          ki    = data[GAIN_W-1:0];
          integ = '0;
        end
        REG_PERIOD: period   = data[PERIOD_W-1:0];
        REG_HIGH:   level_hi = data[SAMPLE_W-1:0];
        REG_LOW:    level_lo = data[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_tick(logic [SAMPLE_W-1:0] sample, logic start);
      tick_res_t           r;
      logic [SAMPLE_W-1:0] lvl;
      int                  e;
      int                  acc;
      longint              u;
      lvl = cur_level();
      e   = int'(lvl) - int'(sample);
      acc = int'(integ) + e;
      if (acc > INT_LIMIT) acc = INT_LIMIT;
      else if (acc < -INT_LIMIT) acc = -INT_LIMIT;
      integ = acc[INTEG_W-1:0];
      u = longint'(kp) * e + longint'(ki) * acc + longint'(PCT_HALF);
      if (u > longint'(PCT_FULL)) u = longint'(PCT_FULL);
      else if (u < 0) u = 0;
      r = '0;
      r.duty = CMP_W'((u * longint'(period)) / longint'(PCT_FULL));
      if (start) capturing = 1'b1;
      if (capturing) begin
        dec_cnt = dec_cnt + 1'b1;
        if (dec_cnt == DECIMATION) begin
          dec_cnt         = '0;
          r.cap.valid     = 1'b1;
          r.cap.index     = cap_pos;
          r.cap.measured  = sample;
          r.cap.reference = lvl;
          cap_pos         = cap_pos + 1'b1;
        end
        if (cap_pos == PLOT_POINTS) begin
          cap_pos    = '0;
          capturing  = 1'b0;
          r.cap.done = r.cap.valid;
        end
      end
      wave_phase = (wave_phase == WAVE_LEN - 1) ? '0 : wave_phase + 1'b1;
      due.push_back(r);
    endfunction

    function void cmp_field(string name, logic [CMP_W-1:0] want, logic [CMP_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [CMP_W-1:0] duty, cap_t cap);
      tick_res_t w;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, duty %0d", $time, duty);
        return;
      end
      w = due.pop_front();
      cmp_field("duty_compare", w.duty, duty);
      cmp_field("capture_valid", CMP_W'(w.cap.valid), CMP_W'(cap.valid));
      cmp_field("capture_index", CMP_W'(w.cap.index), CMP_W'(cap.index));
      cmp_field("capture_measured", CMP_W'(w.cap.measured), CMP_W'(cap.measured));
      cmp_field("capture_reference", CMP_W'(w.cap.reference), CMP_W'(cap.reference));
      cmp_field("capture_done", CMP_W'(w.cap.done), CMP_W'(cap.done));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          steady;
  int          hold_req = 0;
  int unsigned cycles = 0;
  pi_duty_sb   sb;

  pwc_in_if  in_if ();
  pwc_out_if out_if ();
  pwc_cfg_if cfg_if ();

  pi_pwm_controller_with_capture_top #(
    .WAVE_LEN   (WAVE_LEN),
    .PLOT_POINTS(PLOT_POINTS),
    .DECIMATION (DECIMATION),
    .INT_LIMIT  (INT_LIMIT)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      v = int'(sb.cur_level()) + int'($urandom_range(0, 80)) - 40;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
    end else if (k < 9) begin
      v = $urandom_range(0, 1023);
    end else begin
      v = ($urandom_range(0, 1) != 0) ? 1023 : 0;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.apply_write(index, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(input logic [SAMPLE_W-1:0] sample, input logic start);
    int unsigned n;
    if (!steady && $urandom_range(0, 2) == 0) begin
      n = gap_len();
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.adc_sample    <= sample;
    in_if.start_capture <= start;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.predict_tick(sample, start);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_phase(input int p);
    logic [CFG_DATA_W-1:0] kp, ki, per, hi, lo;
    case (p % 5)
      0: begin
        kp = 16'hFFFF; ki = 16'hFFFF; per = 16'hFFFF; hi = 16'd1023; lo = 16'd0;
      end
      1: begin
        kp = 16'd0; ki = 16'd0; per = 16'd0; hi = 16'd0; lo = 16'hFFFF;
      end
      2: begin
        kp  = CFG_DATA_W'($urandom_range(0, 1023));
        ki  = CFG_DATA_W'($urandom_range(0, 63));
        per = 16'd1;
        hi  = CFG_DATA_W'($urandom_range(0, 65535));
        lo  = CFG_DATA_W'($urandom_range(0, 65535));
      end
      default: begin
        kp  = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 1023));
        ki  = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 63));
        per = CFG_DATA_W'($urandom_range(1, 65535));
        hi  = CFG_DATA_W'($urandom_range(0, 65535));
        lo  = CFG_DATA_W'($urandom_range(0, 65535));
      end
    endcase
    cfg_write(REG_PERIOD, per);
    cfg_write(REG_HIGH, hi);
    cfg_write(REG_LOW, lo);
    cfg_write(REG_KP, kp);
    cfg_write(REG_KI, ki);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    int          hold_seen;
    cap_t        seen;
    stall     = 0;
    hold_seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        seen.valid     = out_if.capture_valid;
        seen.index     = out_if.capture_index;
        seen.measured  = out_if.capture_measured;
        seen.reference = out_if.capture_reference;
        seen.done      = out_if.capture_done;
        sb.check_result(out_if.duty_compare, seen);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        stall     = HOLD_CYCLES;
      end else if (stall == 0 && !steady && $urandom_range(0, 3) == 0) begin
        stall = gap_len();
      end
      if (stall != 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int p;
    int i;
    int r;
    int rand_ticks;
    sb                  = new();
    steady              = 1'b0;
    rand_ticks          = 0;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.adc_sample    <= '0;
    in_if.start_capture <= 1'b0;
    out_if.ready        <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_KP;
    cfg_if.data         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults
    send_tick(10'd0, 1'b0);
    send_tick(10'd1023, 1'b0);
    drain();

    // unmapped indexes and wide values
    for (r = REG_LOW + 1; r < 2 ** CFG_IDX_W; r++)
      cfg_write(r[CFG_IDX_W-1:0], CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_write(REG_HIGH, 16'hFFFF);
    cfg_write(REG_LOW, 16'hFC00);
    cfg_write(REG_KP, 16'hFFFF);
    cfg_write(REG_KI, 16'hFFFF);

    // saturate high, arm capture, re-arm while armed
    send_tick(10'd0, 1'b1);
    send_tick(10'd1023, 1'b1);
    send_tick(10'd1023, 1'b0);
    send_tick(10'h155, 1'b0);
    send_tick(10'h2AA, 1'b0);
    drain();

    // integrator to negative limit, duty floor
    cfg_write(REG_HIGH, 16'd0);
    send_tick(10'd1023, 1'b0);
    send_tick(10'd1023, 1'b0);
    send_tick(10'd1023, 1'b0);
    drain();

    cfg_write(REG_KP, 16'd256);
    cfg_write(REG_KI, 16'd1);
    cfg_write(REG_HIGH, 16'd600);
    cfg_write(REG_PERIOD, 16'd1);
    send_tick(10'd590, 1'b0);
    send_tick(10'd610, 1'b0);
    send_tick(10'd600, 1'b0);
    drain();

    cfg_write(REG_PERIOD, 16'hFFFF);
    send_tick(10'd595, 1'b0);
    send_tick(10'd605, 1'b0);
    send_tick(10'd600, 1'b0);
    drain();

    // zero period
    cfg_write(REG_PERIOD, 16'd0);
    send_tick(10'd500, 1'b0);
    send_tick(10'd700, 1'b0);
    drain();

    // random phases
    for (p = 0; p < MAX_PHASES && rand_ticks < RAND_TICKS; p++) begin
      set_phase(p);
      steady = (p % 4 == 3);
      for (i = 0; i < PHASE_TICKS; i++) begin
        if (p % 3 == 1 && i == 100) hold_req++;
        send_tick(pick_sample(), $urandom_range(0, 39) == 0);
        rand_ticks++;
      end
      drain();
    end

    steady = 1'b0;
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
